// ===== hw/rtl/ngs_pkg.sv =====
`default_nettype none
package ngs_pkg;

  localparam int MaxChannelsDef = 4;

  typedef enum logic [1:0] {
    CMD_APPLY   = 2'd0,
    CMD_REQUEST = 2'd1,
    CMD_REPORT  = 2'd2,
    CMD_DONE    = 2'd3
  } cmd_t;

  localparam logic OP_START = 1'b0;
  localparam logic OP_MEAS  = 1'b1;

  localparam logic [2:0] REG_SENSOR = 3'd0;
  localparam logic [2:0] REG_COUNT  = 3'd1;
  localparam logic [2:0] REG_MAP    = 3'd2;
  localparam logic [2:0] REG_STEP   = 3'd3;
  localparam logic [2:0] REG_INIT   = 3'd4;
  localparam logic [2:0] REG_ITER   = 3'd5;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] measurement;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [6:0]         channel_number;
    logic signed [31:0] control_value;
    logic signed [31:0] slope;
    logic [30:0]        correction;
    logic               last;
  } out_item_t;

  // request to the serial divider
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ngs_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle, unsigned 64/64.
module ngs_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ngs_pkg::div_req_t req,
  output ngs_pkg::div_rsp_t     rsp
);
  import ngs_pkg::*;

  logic [63:0] quo_r, quo_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[63:0], quo_r[63]};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      den_nxt  = req.divisor;
      cnt_nxt  = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
endmodule
`default_nettype wire

// ===== hw/rtl/ngs_sqrt.sv =====
`default_nettype none
// Digit-by-digit square root, two radicand bits per cycle.
module ngs_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             done,
  output logic [31:0]      root
);
  import ngs_pkg::*;

  logic [63:0] rad_r, rad_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] tr, tsub;

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    tr   = {rem_r[31:0], rad_r[63:62]};
    tsub = {root_r, 2'b01};
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[61:0], 2'b00};
      if (tr >= tsub) begin
        rem_nxt  = tr - tsub;
        root_nxt = {root_r[30:0], 1'b1};
      end else begin
        rem_nxt  = tr;
        root_nxt = {root_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;
endmodule
`default_nettype wire

// ===== hw/rtl/ngs_mul.sv =====
`default_nettype none
// Shift-add signed multiplier, 32x32 -> 64, one multiplier bit per cycle.
module ngs_mul (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic                    done,
  output logic signed [63:0]      product
);
  import ngs_pkg::*;

  logic signed [63:0] acc_r, acc_nxt;
  logic signed [63:0] mc_r, mc_nxt;
  logic [31:0]        mp_r, mp_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      mc_nxt   = 64'(a);
      mp_nxt   = b;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // top multiplier bit carries negative weight
      if (mp_r[0]) begin
        if (cnt_r == 5'd31) acc_nxt = acc_r - mc_r;
        else                acc_nxt = acc_r + mc_r;
      end
      mc_nxt  = mc_r <<< 1;
      mp_nxt  = {1'b0, mp_r[31:1]};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;
endmodule
`default_nettype wire

// ===== hw/rtl/normalized_gradient_search.sv =====
`default_nettype none
// Extremum-seeking controller over up to MAX_CHANNELS control channels, Q16.16.
// A start item or a measurement item produces up to MAX_CHANNELS+2 result items
// (a measurement while idle produces none). Apply/request items go out one per
// cycle while out_stall is low; in_stall stays high until the last one is taken.
// A start or a first reading goes to output without the serial units. A second
// reading runs the bit-serial divider (not for a zero step) and squarer; on the
// last channel the square root, the correction divide (not for a zero root) and
// one serial multiply per channel follow.
module normalized_gradient_search #(
  parameter int MAX_CHANNELS = ngs_pkg::MaxChannelsDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ngs_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ngs_pkg::out_item_t     out_data,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [63:0]       cfg_data
);
  import ngs_pkg::*;

  localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CW = $clog2(MAX_CHANNELS + 1);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_EMIT   = 11'b00000000010,
    S_DIV    = 11'b00000000100,
    S_SQ     = 11'b00000001000,
    S_SQRT   = 11'b00000010000,
    S_CDIV   = 11'b00000100000,
    S_UPD    = 11'b00001000000,
    S_UPDW   = 11'b00010000000,
    S_REP    = 11'b00100000000,
    S_BEGIN  = 11'b01000000000,
    S_WAITO  = 11'b10000000000
  } state_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_FIRST  = 3'b010,
    PH_SECOND = 3'b100
  } phase_t;

  // emit program: which pair/single to send
  typedef enum logic [2:0] {
    E_APPLY_U  = 3'b001,
    E_APPLY_UD = 3'b010,
    E_DONE     = 3'b100
  } emit_t;

  logic [6:0]  sensor_r;
  logic [2:0]  count_r;
  logic [7:0]  map_r;
  logic [30:0] step_r;
  logic [63:0] init_r;
  logic [15:0] iter_r;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  emit_t  emit_r, emit_nxt;
  logic   esub_r, esub_nxt;

  logic signed [31:0] ctl_r [MAX_CHANNELS];
  logic signed [31:0] ctl_nxt [MAX_CHANNELS];
  logic signed [31:0] slp_r [MAX_CHANNELS];
  logic signed [31:0] slp_nxt [MAX_CHANNELS];
  logic signed [31:0] first_r, first_nxt;
  logic [63:0]  sum_r, sum_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic [15:0]  done_r, done_nxt;
  logic [30:0]  corr_r, corr_nxt;
  logic         neg_r, neg_nxt;
  logic         finish_r, finish_nxt;

  logic       ov_r, ov_nxt;
  out_item_t  od_r, od_nxt;

  div_req_t dreq;
  div_rsp_t drsp;
  logic     sq_start, sqrt_start, sqrt_done, mul_done;
  logic [31:0] root;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;

  logic [CW-1:0] active;
  logic [IW-1:0] last_idx;
  logic          accept;
  logic signed [32:0] diff;
  logic [32:0] mag;
  logic [63:0] q;
  logic signed [65:0] d_s;
  logic [64:0] sum_w;

  ngs_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
  ngs_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sqrt_start), .radicand(sum_r),
                   .done(sqrt_done), .root(root));
  ngs_mul u_mul (.clk(clk), .rst_n(rst_n), .start(sq_start), .a(ma), .b(mb),
                 .done(mul_done), .product(prod));

  function automatic logic [6:0] chan_of(input logic [7:0] m, input logic [1:0] i);
    return 7'd7 + {5'd0, m[2*i +: 2]};
  endfunction

  always_comb begin
    if (count_r == 3'd0) active = CW'(1);
    else if ({29'd0, count_r} > 32'(MAX_CHANNELS)) active = CW'(MAX_CHANNELS);
    else active = CW'(count_r);
  end
  assign last_idx = IW'(active - CW'(1));

  assign in_stall = (state_r != S_IDLE) || ov_r;
  assign accept   = in_valid && !in_stall;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    diff = 33'(in_data.measurement) - 33'(first_r);
    mag  = diff[32] ? 33'(-diff) : diff;
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    emit_nxt  = emit_r;
    esub_nxt  = esub_r;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      ctl_nxt[i] = ctl_r[i];
      slp_nxt[i] = slp_r[i];
    end
    first_nxt  = first_r;
    sum_nxt    = sum_r;
    idx_nxt    = idx_r;
    k_nxt      = k_r;
    done_nxt   = done_r;
    corr_nxt   = corr_r;
    neg_nxt    = neg_r;
    finish_nxt = finish_r;
    ov_nxt     = ov_r && out_stall;
    od_nxt     = od_r;
    dreq       = '0;
    sq_start   = 1'b0;
    sqrt_start = 1'b0;
    ma         = '0;
    mb         = '0;
    q          = drsp.quotient;
    d_s        = '0;
    sum_w      = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.operation == OP_START) begin
            // Q8.8 start value, sign-extended to Q16.16
            for (int i = 0; i < MAX_CHANNELS; i++) begin
              ctl_nxt[i] = {{8{init_r[16*(i%4) + 15]}}, init_r[16*(i%4) +: 16], 8'd0};
            end
            done_nxt  = '0;
            state_nxt = S_BEGIN;
          end else if (phase_r == PH_FIRST) begin
            first_nxt = in_data.measurement;
            emit_nxt  = E_APPLY_UD;
            esub_nxt  = 1'b0;
            finish_nxt = 1'b1;
            phase_nxt = PH_SECOND;
            state_nxt = S_EMIT;
          end else if (phase_r == PH_SECOND) begin
            neg_nxt = diff[32];
            if (step_r == '0) begin
              slp_nxt[idx_r] = '0;
              state_nxt = S_SQ;
              sq_start  = 1'b1;
              ma = '0;
              mb = '0;
            end else begin
              dreq.start    = 1'b1;
              dreq.dividend = {15'd0, mag, 16'd0};
              dreq.divisor  = {33'd0, step_r};
              state_nxt     = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        if (drsp.done) begin
          d_s = neg_r ? -$signed({2'b00, q}) : $signed({2'b00, q});
          slp_nxt[idx_r] = sat32(d_s);
          ma = sat32(d_s);
          mb = sat32(d_s);
          sq_start  = 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        if (mul_done) begin
          sum_w = {1'b0, sum_r} + {1'b0, prod};
          sum_nxt = sum_w[64] ? '1 : sum_w[63:0];
          if (idx_r < last_idx) begin
            idx_nxt    = idx_r + IW'(1);
            emit_nxt   = E_APPLY_U;
            esub_nxt   = 1'b0;
            finish_nxt = 1'b1;
            phase_nxt  = PH_FIRST;
            state_nxt  = S_EMIT;
          end else begin
            state_nxt = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        // start on entry, then wait
        if (!sqrt_done && !finish_r) begin
          sqrt_start = 1'b1;
          finish_nxt = 1'b1;
        end else if (sqrt_done) begin
          finish_nxt = 1'b0;
          if (root == '0) begin
            corr_nxt  = '0;
            k_nxt     = '0;
            state_nxt = S_UPD;
          end else begin
            dreq.start    = 1'b1;
            dreq.dividend = {17'd0, step_r, 16'd0};
            dreq.divisor  = {32'd0, root};
            state_nxt     = S_CDIV;
          end
        end
      end
      S_CDIV: begin
        if (drsp.done) begin
          corr_nxt  = (q > 64'h7fffffff) ? 31'h7fffffff : q[30:0];
          k_nxt     = '0;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        ma = {1'b0, corr_r};
        mb = slp_r[k_r];
        sq_start  = 1'b1;
        state_nxt = S_UPDW;
      end
      S_UPDW: begin
        if (mul_done) begin
          // floor division by 65536 is an arithmetic shift
          d_s = 66'(prod >>> 16);
          ctl_nxt[k_r] = sat32(66'(ctl_r[k_r]) + d_s);
          state_nxt = S_REP;
        end
      end
      S_REP: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          od_nxt.command        = CMD_REPORT;
          od_nxt.channel_number = chan_of(map_r, 2'(k_r));
          od_nxt.control_value  = ctl_r[k_r];
          od_nxt.slope          = slp_r[k_r];
          od_nxt.correction     = corr_r;
          od_nxt.last           = 1'b0;
          if (k_r == idx_r) begin
            done_nxt  = done_r + 16'd1;
            state_nxt = S_BEGIN;
          end else begin
            k_nxt     = k_r + IW'(1);
            state_nxt = S_UPD;
          end
        end
      end
      S_BEGIN: begin
        idx_nxt    = '0;
        sum_nxt    = '0;
        esub_nxt   = 1'b0;
        finish_nxt = 1'b1;
        if (done_r >= iter_r) begin
          emit_nxt  = E_DONE;
          phase_nxt = PH_IDLE;
        end else begin
          emit_nxt  = E_APPLY_U;
          phase_nxt = PH_FIRST;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          od_nxt = '0;
          if (emit_r == E_DONE) begin
            od_nxt.command = CMD_DONE;
            od_nxt.last    = 1'b1;
            state_nxt      = S_WAITO;
          end else if (!esub_r) begin
            od_nxt.command        = CMD_APPLY;
            od_nxt.channel_number = chan_of(map_r, 2'(idx_r));
            od_nxt.control_value  = (emit_r == E_APPLY_UD) ?
                sat32(66'(ctl_r[idx_r]) + 66'(step_r)) : ctl_r[idx_r];
            esub_nxt = 1'b1;
          end else begin
            od_nxt.command        = CMD_REQUEST;
            od_nxt.channel_number = sensor_r;
            od_nxt.last           = 1'b1;
            state_nxt             = S_WAITO;
          end
        end
      end
      S_WAITO: begin
        finish_nxt = 1'b0;
        if (!ov_r || !out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      phase_r  <= PH_IDLE;
      ov_r     <= 1'b0;
      sensor_r <= 7'd1;
      count_r  <= 3'd1;
      map_r    <= 8'd0;
      step_r   <= 31'd65536;
      init_r   <= '0;
      iter_r   <= 16'd1;
      first_r  <= '0;
      sum_r    <= '0;
      idx_r    <= '0;
      done_r   <= '0;
      finish_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      ov_r     <= ov_nxt;
      first_r  <= first_nxt;
      sum_r    <= sum_nxt;
      idx_r    <= idx_nxt;
      done_r   <= done_nxt;
      finish_r <= finish_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_SENSOR: sensor_r <= cfg_data[6:0];
          REG_COUNT:  count_r  <= cfg_data[2:0];
          REG_MAP:    map_r    <= cfg_data[7:0];
          REG_STEP:   step_r   <= cfg_data[30:0];
          REG_INIT:   init_r   <= cfg_data;
          REG_ITER:   iter_r   <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
    emit_r <= emit_nxt;
    esub_r <= esub_nxt;
    k_r    <= k_nxt;
    corr_r <= corr_nxt;
    neg_r  <= neg_nxt;
    od_r   <= od_nxt;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      ctl_r[i] <= ctl_nxt[i];
      slp_r[i] <= slp_nxt[i];
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/ngs_checker.sv =====
`default_nettype none
module ngs_props (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire ngs_pkg::out_item_t out_data
);
  import ngs_pkg::*;

  // no new item taken while a result still waits
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open with result pending");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.command == CMD_DONE |-> out_data.last &&
    out_data.channel_number == 7'd0) else $error("bad finished item");

  a_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.command == CMD_REQUEST |-> out_data.last)
    else $error("request not last");
endmodule

bind normalized_gradient_search ngs_props u_ngs_props (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

// ===== verif/ngs_checker.sv =====
`timescale 1ns / 1ps
module ngs_checker
  import ngs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_stall,
  input  wire in_item_t  in_data,
  input  wire logic      out_valid,
  input  wire logic      out_stall,
  input  wire out_item_t out_data,
  input  wire logic      cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [63:0] cfg_data,
  output int             errors,
  output int             pending
);

  localparam int NCH = MaxChannelsDef;

  typedef enum logic [1:0] {SRCH_IDLE, SRCH_FIRST, SRCH_SECOND} srch_t;

  logic [6:0]  sensor_r;
  logic [2:0]  count_r;
  logic [7:0]  map_r;
  logic [30:0] step_r;
  logic [63:0] init_r;
  logic [15:0] iter_r;

  logic signed [31:0] ctl_u [NCH];
  logic signed [31:0] grad [NCH];
  logic signed [31:0] first_meas;
  logic [63:0]        grad_sq_sum;
  int unsigned        chan_idx;
  srch_t              srch;
  logic [15:0]        iters_done;

  out_item_t want_q[$];

  assign pending = want_q.size();

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] int_root(input logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic int unsigned used_chans();
    int unsigned n;
    n = count_r;
    if (n < 1) n = 1;
    if (n > NCH) n = NCH;
    return n;
  endfunction

  function automatic logic [6:0] ctl_chan(input int unsigned i);
    return 7'd7 + 7'(map_r[2*(i%4) +: 2]);
  endfunction

  task automatic push(input cmd_t c, input logic [6:0] ch, input logic signed [31:0] v,
                      input logic signed [31:0] s, input logic [30:0] k);
    out_item_t o;
    o.command = c;
    o.channel_number = ch;
    o.control_value = v;
    o.slope = s;
    o.correction = k;
    o.last = 1'b0;
    want_q.push_back(o);
  endtask

  task automatic open_channel();
    push(CMD_APPLY, ctl_chan(chan_idx), ctl_u[chan_idx], '0, '0);
    push(CMD_REQUEST, sensor_r, '0, '0, '0);
    srch = SRCH_FIRST;
  endtask

  task automatic open_iteration();
    chan_idx = 0;
    grad_sq_sum = '0;
    if (iters_done >= iter_r) begin
      push(CMD_DONE, '0, '0, '0, '0);
      srch = SRCH_IDLE;
    end else begin
      open_channel();
    end
  endtask

  task automatic predict(input in_item_t it);
    int n0;
    longint step_l, p;
    logic signed [31:0] s;
    logic [63:0] sq, root, c;
    logic [15:0] raw;
    out_item_t o;
    n0 = want_q.size();
    step_l = longint'({33'd0, step_r});
    if (it.operation == OP_START) begin
      for (int i = 0; i < NCH; i++) begin
        raw = init_r[16*(i%4) +: 16];
        ctl_u[i] = {{8{raw[15]}}, raw, 8'h00};
      end
      iters_done = '0;
      open_iteration();
    end else if (srch == SRCH_FIRST) begin
      first_meas = it.measurement;
      push(CMD_APPLY, ctl_chan(chan_idx), clip32(longint'(ctl_u[chan_idx]) + step_l), '0, '0);
      push(CMD_REQUEST, sensor_r, '0, '0, '0);
      srch = SRCH_SECOND;
    end else if (srch == SRCH_SECOND) begin
      s = '0;
      if (step_l != 0)
        s = clip32(((longint'(it.measurement) - longint'(first_meas)) * 65536) / step_l);
      grad[chan_idx] = s;
      sq = 64'(longint'(s) * longint'(s));
      grad_sq_sum = (grad_sq_sum > ~64'd0 - sq) ? ~64'd0 : grad_sq_sum + sq;
      if (chan_idx + 1 < used_chans()) begin
        chan_idx++;
        open_channel();
      end else begin
        root = int_root(grad_sq_sum);
        c = '0;
        if (root != 0) begin
          c = (64'(step_r) << 16) / root;
          if (c > 64'h7fff_ffff) c = 64'h7fff_ffff;
        end
        for (int unsigned k = 0; k <= chan_idx; k++) begin
          p = longint'(c) * longint'(grad[k]);
          ctl_u[k] = clip32(longint'(ctl_u[k]) + (p >>> 16));
          push(CMD_REPORT, ctl_chan(k), ctl_u[k], grad[k], c[30:0]);
        end
        iters_done++;
        open_iteration();
      end
    end
    if (want_q.size() > n0) begin
      o = want_q.pop_back();
      o.last = 1'b1;
      want_q.push_back(o);
    end
  endtask

  always @(posedge clk) begin
    out_item_t w;
    if (!rst_n) begin
      sensor_r = 7'd1;
      count_r = 3'd1;
      map_r = '0;
      step_r = 31'd65536;
      init_r = '0;
      iter_r = 16'd1;
      first_meas = '0;
      grad_sq_sum = '0;
      chan_idx = 0;
      srch = SRCH_IDLE;
      iters_done = '0;
      errors <= 0;
      want_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SENSOR: sensor_r = cfg_data[6:0];
          REG_COUNT:  count_r = cfg_data[2:0];
          REG_MAP:    map_r = cfg_data[7:0];
          REG_STEP:   step_r = cfg_data[30:0];
          REG_INIT:   init_r = cfg_data;
          REG_ITER:   iter_r = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict(in_data);
      if (out_valid && !out_stall) begin
        if (want_q.size() == 0) begin
          $display("%0t: unexpected item %p", $time, out_data);
          errors <= errors + 1;
        end else begin
          w = want_q.pop_front();
          if (w != out_data) begin
            $display("%0t: mismatch expected %p actual %p", $time, w, out_data);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import ngs_pkg::*;

  localparam int IDLE_LIMIT = 6000;
  localparam int SETTLE = 500;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int        errors, pending;

  bit tx_quiet, rx_quiet, hold_go, hold_done;
  int rx_gap, rx_hold, idle_cycles, n_items;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  normalized_gradient_search dut (.*);

  ngs_checker chk (.*);

  // receiver: random stall after each item, plus one long hold-off on request
  always @(posedge clk) begin
    logic nxt;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_gap = 0;
      rx_hold = 0;
      hold_done = 1'b0;
    end else begin
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        rx_hold = 300;
      end
      if (out_valid && !out_stall) rx_gap = rx_quiet ? 0 : $urandom_range(0, 11);
      nxt = 1'b0;
      if (rx_hold > 0) begin
        rx_hold--;
        nxt = 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        nxt = 1'b1;
      end
      out_stall <= nxt;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic send(input logic op, input logic [31:0] meas);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{operation: op, measurement: meas};
    do @(posedge clk); while (in_stall);
    n_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(input logic [6:0] sen, input logic [2:0] cnt, input logic [7:0] map,
                           input logic [30:0] stp, input logic [63:0] init,
                           input logic [15:0] iters);
    logic [63:0] vals [6];
    vals = '{64'(sen), 64'(cnt), 64'(map), 64'(stp), init, 64'(iters)};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_meas();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
    endcase
  endfunction

  initial begin
    int chans, iters, n_meas;
    logic [15:0] iter_v;
    logic [30:0] step_v;
    n_items = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: measurement while idle is dropped, then one channel, one iteration
    send(OP_MEAS, 32'h1234_5678);
    send(OP_START, '0);
    send(OP_MEAS, 32'h0001_0000);
    send(OP_MEAS, 32'h0003_0000);
    drain();

    // channel count zero, zero step
    configure(7'd0, 3'd0, 8'hff, 31'd0, 64'hffff_ffff_ffff_ffff, 16'd1);
    send(OP_START, '0);
    send(OP_MEAS, 32'h8000_0000);
    send(OP_MEAS, 32'h7fff_ffff);
    drain();

    // zero iterations
    configure(7'd127, 3'd4, 8'h1b, 31'd1, 64'h7fff_8000_0100_ff00, 16'd0);
    send(OP_START, '0);
    drain();

    // count above range, largest step, restart while searching, extreme readings
    configure(7'd90, 3'd7, 8'he4, 31'h7fff_ffff, 64'h8000_7fff_8000_7fff, 16'd2);
    send(OP_START, '0);
    send(OP_MEAS, 32'h8000_0000);
    send(OP_START, '0);
    for (int i = 0; i < 8; i++) send(OP_MEAS, i[0] ? 32'h7fff_ffff : 32'h8000_0000);
    drain();

    // smallest step, one reading delta of one lsb
    configure(7'd11, 3'd1, 8'h00, 31'd1, 64'h0000_0000_0000_0001, 16'd1);
    send(OP_START, '0);
    send(OP_MEAS, 32'hffff_ffff);
    send(OP_MEAS, 32'h0000_0000);
    drain();

    // receiver holds off while the sender keeps offering
    hold_go = 1'b1;
    configure(7'd6, 3'd4, 8'h39, 31'd65536, {$urandom, $urandom}, 16'd1);
    send(OP_START, '0);
    for (int i = 0; i < 8; i++) send(OP_MEAS, rand_meas());
    drain();

    while (n_items < 175) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0: step_v = 31'h7fff_ffff;
        1: step_v = 31'(1 << $urandom_range(0, 8));
        2: step_v = 31'd0;
        default: step_v = 31'($urandom >> $urandom_range(1, 24));
      endcase
      iter_v = ($urandom_range(0, 9) == 0) ? 16'hffff : 16'($urandom_range(0, 3));
      configure(7'($urandom), 3'($urandom), 8'($urandom), step_v, {$urandom, $urandom}, iter_v);
      chans = int'(chk.used_chans());
      iters = (iter_v > 3) ? 2 : int'(iter_v);
      n_meas = 2 * chans * iters + $urandom_range(0, 2);
      send(OP_START, '0);
      for (int i = 0; i < n_meas; i++) begin
        if ($urandom_range(0, 29) == 0) send(OP_START, '0);
        else send(OP_MEAS, rand_meas());
      end
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== normalized_gradient_search.f =====
hw/rtl/ngs_pkg.sv
hw/rtl/ngs_div.sv
hw/rtl/ngs_sqrt.sv
hw/rtl/ngs_mul.sv
hw/rtl/normalized_gradient_search.sv
hw/rtl/ngs_checker.sv
verif/ngs_checker.sv
verif/tb_top.sv
